[src/rldf_pkg.sv]
`timescale 1ns / 1ps

package rldf_pkg;

    // Default sizes of the bin store
    localparam int unsigned NUM_BINS_DEF  = 4096;
    localparam int unsigned BIN_DEPTH_DEF = 8;

    // Field widths
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned KEY_W     = 64;
    localparam int unsigned VERDICT_W = 3;
    localparam int unsigned LIMIT_W   = 4;

    // Line request queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd8;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;

    // Verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        V_COMMENT   = 3'd0,
        V_BAD       = 3'd1,
        V_DUPLICATE = 3'd2,
        V_STORED    = 3'd3,
        V_FULL      = 3'd4
    } t_verdict;

endpackage

[src/rldf_if.sv]
`timescale 1ns / 1ps

interface rldf_in_if import rldf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              line_end;

    modport source(output valid, output char_code, output line_end, input ready);
    modport sink(input valid, input char_code, input line_end, output ready);
endinterface

interface rldf_out_if import rldf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [KEY_W-1:0]     line_key;

    modport source(output valid, output verdict, output line_key, input ready);
    modport sink(input valid, input verdict, input line_key, output ready);
endinterface

[src/relation_line_dedup_filter_top.sv]
`timescale 1ns / 1ps
// Characters are taken one per cycle while the 4-deep line request queue has room.
// A lookup request leaves the queue and has its key folded until the upper half is zero;
// a reciprocal quotient, remainder and fix-up then give the bin, the bin fill is read,
// and each stored entry is read and compared in turn, the search ending at a duplicate;
// comment and bad lines go straight to the output. The verdict shows from the result register.
// After reset the fill memory is cleared, one bin a cycle, during which no
// character is taken; the bin limit resets to 8.
module relation_line_dedup_filter_top import rldf_pkg::*; #(
    parameter int unsigned NUM_BINS  = NUM_BINS_DEF,
    parameter int unsigned BIN_DEPTH = BIN_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    rldf_in_if.sink            i_line,
    rldf_out_if.source         o_verdict
);

    localparam int unsigned BW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int unsigned FW  = $clog2(BIN_DEPTH + 1);
    localparam int unsigned LW  = (FW > LIMIT_W) ? FW : LIMIT_W;
    localparam int unsigned ED  = NUM_BINS * BIN_DEPTH;
    localparam int unsigned EAW = (ED > 1) ? $clog2(ED) : 1;

    // Folding constant (2^32 mod bins) and reciprocal (2^32 / bins)
    localparam logic [31:0]      FOLD_C  = 32'((64'd1 << 32) % 64'(NUM_BINS));
    localparam logic [32:0]      RECIP   = 33'((64'd1 << 32) / 64'(NUM_BINS));
    localparam logic [KEY_W-1:0] BINS_K  = KEY_W'(NUM_BINS);
    localparam logic [KEY_W-1:0] BINS_K2 = KEY_W'(2 * NUM_BINS);

    typedef enum logic [7:0] {
        PH_START     = 8'b0000_0001,
        PH_COMMENT   = 8'b0000_0010,
        PH_SKIPWS    = 8'b0000_0100,
        PH_KEY       = 8'b0000_1000,
        PH_COLON     = 8'b0001_0000,
        PH_BAD       = 8'b0010_0000,
        PH_KEYDONE   = 8'b0100_0000,
        PH_COLONDONE = 8'b1000_0000
    } t_phase;

    typedef enum logic [11:0] {
        E_CLEAR  = 12'b0000_0000_0001,
        E_IDLE   = 12'b0000_0000_0010,
        E_MOD    = 12'b0000_0000_0100,
        E_QUO    = 12'b0000_0000_1000,
        E_REM    = 12'b0000_0001_0000,
        E_FIX    = 12'b0000_0010_0000,
        E_FRD    = 12'b0000_0100_0000,
        E_FWAIT  = 12'b0000_1000_0000,
        E_SRD    = 12'b0001_0000_0000,
        E_SCMP   = 12'b0010_0000_0000,
        E_DECIDE = 12'b0100_0000_0000,
        E_OUT    = 12'b1000_0000_0000
    } t_eng;

    // ---------------- configuration ----------------
    logic [LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // ---------------- line parser ----------------
    t_phase            r_phase, n_phase, ph;
    logic [KEY_W-1:0]  r_key_acc, n_key_acc;
    logic [1:0]        r_pos;
    logic [15:0]       r_prev;
    logic              r_shape, n_shape;
    logic [1:0]        r_colons, n_colons;
    logic [CHAR_W-1:0] c;
    logic              is_ws, is_digit, do_key, accept, push;
    logic [KEY_W-1:0]  key_x11, key_digit;
    logic [KEY_W-1:0]  push_key;
    logic              push_look;
    t_verdict          push_verd;
    t_eng              r_eng;
    logic [2:0]        r_qcnt;

    assign c        = i_line.char_code;
    assign is_ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign key_x11  = (r_key_acc << 3) + (r_key_acc << 1) + r_key_acc;
    assign key_digit = is_digit ? {{(KEY_W-CHAR_W){1'b0}}, c - CH_ZERO} : KEY_W'(10);

    assign i_line.ready = (r_eng != E_CLEAR) && (r_qcnt != 3'(Q_DEPTH));
    assign accept       = i_line.valid && i_line.ready;
    assign push         = accept && i_line.line_end;

    // Work out one character step
    always_comb begin
        n_phase   = r_phase;
        n_key_acc = r_key_acc;
        n_shape   = r_shape;
        n_colons  = r_colons;
        ph        = r_phase;
        if (r_phase == PH_START) begin
            ph      = (c == CH_HASH || c == CH_N) ? PH_COMMENT : PH_SKIPWS;
            n_phase = ph;
        end
        do_key = (ph == PH_KEY) ||
                 (ph == PH_SKIPWS && c != CH_NUL && !is_ws && c != CH_MINUS);
        case (ph)
            PH_SKIPWS: begin
                if (c == CH_NUL) begin
                    n_phase = PH_KEYDONE;
                end else if (c == CH_MINUS) begin
                    n_key_acc = KEY_W'(10);
                    n_phase   = PH_KEY;
                end else if (!is_ws) begin
                    n_phase = PH_KEY;
                end
            end
            PH_COLON: begin
                if (c == CH_NUL) begin
                    n_phase = PH_COLONDONE;
                end else if (c == CH_COLON && r_colons != 2'd3) begin
                    n_colons = r_colons + 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (do_key) begin
            if (is_digit || c == CH_COMMA) begin
                n_key_acc = key_x11 + key_digit;
            end else if (c == CH_COLON) begin
                n_shape = (r_pos == 2'd3) && (r_prev[15:8] == CH_COMMA) &&
                          (r_prev[7:0] == CH_ZERO);
                n_phase = PH_COLON;
            end else if (c == CH_NUL) begin
                n_phase = PH_KEYDONE;
            end else begin
                n_phase = PH_BAD;
            end
        end
    end

    // Form the line request
    always_comb begin
        push_key  = '0;
        push_look = 1'b0;
        push_verd = V_BAD;
        case (n_phase)
            PH_COMMENT: begin
                push_verd = V_COMMENT;
            end
            PH_COLON, PH_COLONDONE: begin
                if (n_shape || n_colons == 2'd1) begin
                    push_key  = n_key_acc;
                    push_look = 1'b1;
                end
            end
            PH_SKIPWS, PH_KEY, PH_KEYDONE: begin
                push_key  = n_key_acc;
                push_look = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Advance the parser; clear it at line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || push) begin
            r_phase   <= PH_START;
            r_key_acc <= '0;
            r_pos     <= '0;
            r_prev    <= '0;
            r_shape   <= 1'b0;
            r_colons  <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_key_acc <= n_key_acc;
            r_shape   <= n_shape;
            r_colons  <= n_colons;
            r_prev    <= {r_prev[7:0], c};
            if (r_pos != 2'd3) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    // ---------------- request queue ----------------
    logic [KEY_W-1:0] q_key  [Q_DEPTH];
    logic             q_look [Q_DEPTH];
    t_verdict         q_verd [Q_DEPTH];
    logic [Q_AW-1:0]  r_qwr, r_qrd;
    logic             pop;

    assign pop = (r_eng == E_IDLE) && (r_qcnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            q_key[r_qwr]  <= push_key;
            q_look[r_qwr] <= push_look;
            q_verd[r_qwr] <= push_verd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qwr  <= '0;
            r_qrd  <= '0;
            r_qcnt <= '0;
        end else begin
            if (push) begin
                r_qwr <= r_qwr + 1'b1;
            end
            if (pop) begin
                r_qrd <= r_qrd + 1'b1;
            end
            if (push && !pop) begin
                r_qcnt <= r_qcnt + 3'd1;
            end else if (pop && !push) begin
                r_qcnt <= r_qcnt - 3'd1;
            end
        end
    end

    // ---------------- lookup engine ----------------
    logic [FW-1:0]    fill_mem [NUM_BINS];
    logic [KEY_W-1:0] ent_mem  [ED];
    logic [FW-1:0]    r_fill_q, r_fill;
    logic [KEY_W-1:0] r_ent_q, r_key;
    t_verdict         r_verd;
    logic [BW-1:0]    r_clr, r_bin;
    logic [KEY_W-1:0] r_x;
    logic [31:0]      r_q;
    logic [KEY_W-1:0] fold_prod, fold_sum, m_prod, fix_rem;
    logic [64:0]      q_prod;
    logic [EAW-1:0]   r_base, ent_addr;
    logic [FW-1:0]    r_slot;
    logic [LW-1:0]    lim;
    logic             fill_we, ent_we, fill_re, ent_re;
    logic [BW-1:0]    fill_addr;
    logic [FW-1:0]    fill_wd;
    logic             r_ov;
    t_verdict         r_overd;
    logic [KEY_W-1:0] r_okey;
    logic             out_free;

    // Bin remainder: fold the upper half down, then a reciprocal quotient
    assign fold_prod = r_x[63:32] * FOLD_C;
    assign fold_sum  = fold_prod + {32'b0, r_x[31:0]};
    assign q_prod    = r_x[31:0] * RECIP;
    assign m_prod    = r_q * NUM_BINS;
    assign fix_rem   = (r_x >= BINS_K2) ? r_x - BINS_K2 :
                       (r_x >= BINS_K)  ? r_x - BINS_K  : r_x;

    assign lim      = (LW'(r_limit) > LW'(BIN_DEPTH)) ? LW'(BIN_DEPTH) : LW'(r_limit);
    assign ent_addr = r_base + EAW'(r_slot);
    assign out_free = !r_ov || o_verdict.ready;

    // Memory port controls
    always_comb begin
        fill_we   = 1'b0;
        fill_re   = 1'b0;
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        fill_addr = r_bin;
        fill_wd   = r_fill + FW'(1);
        case (r_eng)
            E_CLEAR: begin
                fill_we   = 1'b1;
                fill_addr = r_clr;
                fill_wd   = '0;
            end
            E_FRD: begin
                fill_re = 1'b1;
            end
            E_SRD: begin
                ent_re = (r_slot != r_fill);
            end
            E_DECIDE: begin
                fill_we = (LW'(r_fill) < lim);
                ent_we  = (LW'(r_fill) < lim);
            end
            default: begin
            end
        endcase
    end

    // Fill memory
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_addr] <= fill_wd;
        end
        if (fill_re) begin
            r_fill_q <= fill_mem[fill_addr];
        end
    end

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_addr] <= r_key;
        end
        if (ent_re) begin
            r_ent_q <= ent_mem[ent_addr];
        end
    end

    // Sequence one request at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng <= E_CLEAR;
            r_clr <= '0;
        end else begin
            case (r_eng)
                E_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BW'(NUM_BINS - 1)) begin
                        r_eng <= E_IDLE;
                    end
                end
                E_IDLE: begin
                    if (pop) begin
                        r_key  <= q_key[r_qrd];
                        r_x    <= q_key[r_qrd];
                        r_verd <= q_verd[r_qrd];
                        r_eng  <= q_look[r_qrd] ? E_MOD : E_OUT;
                    end
                end
                E_MOD: begin
                    if (r_x[63:32] == '0) begin
                        r_eng <= E_QUO;
                    end else begin
                        r_x <= fold_sum;
                    end
                end
                E_QUO: begin
                    r_q   <= 32'(q_prod >> 32);
                    r_eng <= E_REM;
                end
                E_REM: begin
                    r_x   <= r_x - m_prod;
                    r_eng <= E_FIX;
                end
                E_FIX: begin
                    r_bin <= fix_rem[BW-1:0];
                    r_eng <= E_FRD;
                end
                E_FRD: begin
                    r_eng <= E_FWAIT;
                end
                E_FWAIT: begin
                    r_fill <= r_fill_q;
                    r_base <= EAW'(r_bin) * EAW'(BIN_DEPTH);
                    r_slot <= '0;
                    r_eng  <= E_SRD;
                end
                E_SRD: begin
                    r_eng <= (r_slot == r_fill) ? E_DECIDE : E_SCMP;
                end
                E_SCMP: begin
                    if (r_ent_q == r_key) begin
                        r_verd <= V_DUPLICATE;
                        r_eng  <= E_OUT;
                    end else begin
                        r_slot <= r_slot + FW'(1);
                        r_eng  <= E_SRD;
                    end
                end
                E_DECIDE: begin
                    r_verd <= (LW'(r_fill) < lim) ? V_STORED : V_FULL;
                    r_eng  <= E_OUT;
                end
                E_OUT: begin
                    if (out_free) begin
                        r_eng <= E_IDLE;
                    end
                end
                default: begin
                    r_eng <= E_IDLE;
                end
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_eng == E_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (o_verdict.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_eng == E_OUT && out_free) begin
            r_overd <= r_verd;
            r_okey  <= r_key;
        end
    end

    assign o_verdict.valid    = r_ov;
    assign o_verdict.verdict  = r_overd;
    assign o_verdict.line_key = r_okey;

endmodule
